>>> rtl/dpc_pkg.sv
// Package: types, constants and register codes for the disparity to point cloud core.
`default_nettype none
package dpc_pkg;
   localparam int MaxWidthDefault  = 4096;
   localparam int MaxHeightDefault = 4096;
   localparam int RowLimitHw       = 8191;
   localparam int CntW             = 13;
   localparam int CsrIdxW          = 3;
   localparam int CsrDataW         = 16;
   localparam int QuoW             = 64;
   localparam int DivCntW          = 7;

   localparam logic [CsrIdxW-1:0] REG_FOCAL    = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_BASELINE = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_CENTER_X = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_LINE_W   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_WIDE     = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_WHITE    = 3'd6;

   typedef struct packed {
      logic [15:0] disparity;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [30:0]        point_z;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the item and counters
      logic mul_z;     // numerator = B*F*coef
      logic div_start; // start a division
      logic div_sel;   // 0: Z, 1: X/Y projection
      logic axis;      // 0: X, 1: Y
      logic mul_p;     // product Zq*|delta|
      logic store;     // latch the quotient
      logic finish;    // assemble the result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic zero_disp;
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/dpc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module dpc_div
   import dpc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [QuoW-1:0] dividend,
   input  wire logic [15:0]     divisor,
   output logic                 done,
   output logic [QuoW-1:0]      quotient
);
   logic [QuoW-1:0]    q_ff, q_in;
   logic [16:0]        r_ff, r_in;
   logic [15:0]        d_ff, d_in;
   logic [DivCntW-1:0] n_ff, n_in;
   logic               busy_ff, busy_in;
   logic [16:0]        trial;
   logic [17:0]        diff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff; busy_in = busy_ff;
      trial = '0; diff = '0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff[15:0], q_ff[QuoW-1]};
         diff  = {1'b0, trial} - {2'b00, d_ff};
         if (!diff[17]) begin
            r_in = diff[16:0];
            q_in = {q_ff[QuoW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[QuoW-2:0], 1'b0};
         end
         n_in = n_ff + 1'b1;
         if (n_ff == DivCntW'(QuoW-1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) begin
         n_ff <= '0; busy_ff <= 1'b0;
      end else begin
         n_ff <= n_in; busy_ff <= busy_in;
      end
   end

   // The quotient is complete once every bit has been shifted in.
   assign quotient = q_ff;
   assign done = !busy_ff && (n_ff == DivCntW'(QuoW));
endmodule
`default_nettype wire

>>> rtl/dpc_datapath.sv
// Datapath: config registers, pixel counters, multipliers, divider and result register.
`default_nettype none
module dpc_datapath
   import dpc_pkg::*;
#(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data,
   input  wire req_type             req_data,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   output rsp_type                  rsp_data
);
   localparam int WLim = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
   localparam int RowMax = (MAX_HEIGHT < RowLimitHw) ? MAX_HEIGHT : RowLimitHw;

   logic [15:0] focal_ff, base_ff, cx_ff, cy_ff;
   logic [12:0] lw_ff;
   logic        wide_ff;
   logic [7:0]  white_ff;
   logic [CntW-1:0] col_ff, col_in, row_ff, row_in;
   req_type     item_ff;
   logic [CntW-1:0] icol_ff, irow_ff;
   logic [15:0] dv_ff;
   logic [QuoW-1:0] num_ff, zq_ff, px_ff, py_ff;
   logic        neg_ff;
   rsp_type     rsp_ff;
   logic [15:0] f_eff;
   logic [CntW-1:0] width, ccur, rcur;
   logic        dv_zero;
   logic [QuoW-1:0] div_q, div_num;
   logic [15:0] div_den;
   logic [17:0] delta;
   logic        dneg;
   logic [16:0] dmag;
   logic        white;
   logic [31:0] bf_prod;

   assign f_eff = (focal_ff == '0) ? 16'd1 : focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= 16'd1; base_ff <= '0; cx_ff <= '0; cy_ff <= '0;
         lw_ff <= 13'd640; wide_ff <= 1'b0; white_ff <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FOCAL:    focal_ff <= csr_data;
            REG_BASELINE: base_ff  <= csr_data;
            REG_CENTER_X: cx_ff    <= csr_data;
            REG_CENTER_Y: cy_ff    <= csr_data;
            REG_LINE_W:   lw_ff    <= csr_data[12:0];
            REG_WIDE:     wide_ff  <= csr_data[0];
            REG_WHITE:    white_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Counters advance when the item is captured.
   always_comb begin
      ccur = req_data.frame_start ? CntW'(1) : col_ff;
      rcur = req_data.frame_start ? CntW'(1) : row_ff;
      width = (lw_ff == '0) ? CntW'(1) : ((32'(lw_ff) > WLim) ? CntW'(WLim) : lw_ff);
      col_in = col_ff; row_in = row_ff;
      if (cmd.load) begin
         if (ccur >= width) begin
            col_in = CntW'(1);
            row_in = (32'(rcur) < RowMax) ? rcur + 1'b1 : rcur;
         end else begin
            col_in = ccur + 1'b1;
            row_in = rcur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= CntW'(1); row_ff <= CntW'(1);
      end else begin
         col_ff <= col_in; row_ff <= row_in;
      end
   end

   assign dv_zero = (dv_ff == '0);
   assign delta = cmd.axis ? ({1'b0, irow_ff, 4'b0} - {2'b00, cy_ff})
                           : ({1'b0, icol_ff, 4'b0} - {2'b00, cx_ff});
   assign dneg = delta[17];
   assign dmag = dneg ? 17'(-delta) : delta[16:0];

   // Full 32-bit product of baseline and focal length.
   assign bf_prod = base_ff * f_eff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         icol_ff <= ccur;
         irow_ff <= rcur;
         dv_ff   <= wide_ff ? req_data.disparity : {8'h00, req_data.disparity[7:0]};
      end
      // The coefficient is 16 for wide disparity and 4 for narrow.
      if (cmd.mul_z)
         num_ff <= wide_ff ? {28'd0, bf_prod, 4'd0} : {30'd0, bf_prod, 2'd0};
      if (cmd.mul_p) begin
         num_ff <= QuoW'(zq_ff[36:0] * dmag);
         neg_ff <= dneg;
      end
      if (cmd.store) begin
         if (!cmd.div_sel) zq_ff <= div_q;
         else if (!cmd.axis) px_ff <= {neg_ff, div_q[QuoW-2:0]};
         else py_ff <= {neg_ff, div_q[QuoW-2:0]};
      end
   end

   assign div_num = num_ff;
   assign div_den = cmd.div_sel ? f_eff : dv_ff;

   dpc_div u_div (
      .clock, .reset, .start(cmd.div_start), .dividend(div_num),
      .divisor(div_den), .done(sts.div_done), .quotient(div_q)
   );

   assign sts.zero_disp = dv_zero;

   function automatic logic [31:0] sat_s(input logic [QuoW-1:0] v);
      logic [QuoW-2:0] m;
      m = v[QuoW-2:0];
      if (v[QuoW-1]) sat_s = (m > 63'h8000_0000) ? 32'h8000_0000 : 32'(-m);
      else sat_s = (m > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   assign white = (item_ff.red > white_ff) && (item_ff.green > white_ff)
                  && (item_ff.blue > white_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.out_red   <= white ? 8'd0 : item_ff.red;
         rsp_ff.out_green <= white ? 8'd0 : item_ff.green;
         rsp_ff.out_blue  <= white ? 8'd0 : item_ff.blue;
         if (white || dv_zero) begin
            rsp_ff.point_x <= '0; rsp_ff.point_y <= '0; rsp_ff.point_z <= '0;
         end else begin
            rsp_ff.point_x <= sat_s(px_ff);
            rsp_ff.point_y <= sat_s(py_ff);
            rsp_ff.point_z <= (zq_ff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : zq_ff[30:0];
         end
      end
   end
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/dpc_ctrl.sv
// Controller: sequences load, up to three divisions and the result handshake.
`default_nettype none
module dpc_ctrl
   import dpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   localparam logic [3:0] S_IDLE = 4'd0, S_MULZ = 4'd1, S_DIVZ = 4'd2, S_WZ = 4'd3,
                          S_MULX = 4'd4, S_DIVX = 4'd5, S_WX = 4'd6, S_MULY = 4'd7,
                          S_DIVY = 4'd8, S_WY = 4'd9, S_FIN = 4'd10;
   logic [3:0] state_ff, state_in;
   logic       vld_ff, vld_in;
   logic       take;

   // Next item may start while the previous result waits in the output register.
   assign req_ready = (state_ff == S_IDLE);
   assign take = req_valid && req_ready;
   assign rsp_valid = vld_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      vld_in = vld_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin cmd.load = take; if (take) state_in = S_MULZ; end
         S_MULZ: begin cmd.mul_z = 1'b1; state_in = S_DIVZ; end
         S_DIVZ: begin
            cmd.div_start = 1'b1;
            state_in = sts.zero_disp ? S_FIN : S_WZ;
         end
         S_WZ: if (sts.div_done) begin cmd.store = 1'b1; state_in = S_MULX; end
         S_MULX: begin cmd.mul_p = 1'b1; state_in = S_DIVX; end
         S_DIVX: begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; state_in = S_WX; end
         S_WX: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin cmd.store = 1'b1; state_in = S_MULY; end
         end
         S_MULY: begin cmd.mul_p = 1'b1; cmd.axis = 1'b1; state_in = S_DIVY; end
         S_DIVY: begin
            cmd.div_start = 1'b1; cmd.div_sel = 1'b1; cmd.axis = 1'b1; state_in = S_WY;
         end
         S_WY: begin
            cmd.div_sel = 1'b1; cmd.axis = 1'b1;
            if (sts.div_done) begin cmd.store = 1'b1; state_in = S_FIN; end
         end
         S_FIN: if (!vld_ff || rsp_ready) begin
            cmd.finish = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
      end
   end

   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("result not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.finish) else $error("result overwritten");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> !req_ready) else $error("accepted while busy");
endmodule
`default_nettype wire

>>> rtl/disparity_to_point_cloud_core.sv
// Top level of the disparity to point cloud core.
// Channel  Ports                    Direction  Carries
// req      req_valid/ready/data     in         one pixel item
// rsp      rsp_valid/ready/data     out        one point item
// csr      csr_valid/ready/index    in         register writes
// Each item runs three 64-step divisions in turn in one shared restoring divider,
// with sequencing states around them. A new item is accepted only once the
// previous result has been handed to the output register.
// Reset is synchronous and sets the control state, pixel counters and config registers.
// A finished item waits in the output register while the next item starts; if
// it is still waiting when the next one is done, the core holds and stops input.
// Zero disparity skips the waits for the divisions and goes straight to the finish state.
`default_nettype none
module disparity_to_point_cloud_core
   import dpc_pkg::*;
#(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   // Configuration writes are always taken; the user must send them only while idle, the core does not enforce this.
   assign csr_ready = 1'b1;

   dpc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   dpc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock, .reset, .csr_we(csr_valid), .csr_index, .csr_data,
      .req_data, .cmd, .sts, .rsp_data
   );
endmodule
`default_nettype wire

>>> tb/sv/tb_disparity_to_point_cloud_core.sv
// Testbench for the disparity to point cloud core: directed table, random phases, self-checking.
`timescale 1ns / 100ps
module tb_disparity_to_point_cloud_core;
   import dpc_pkg::*;

   localparam int RunLimit   = 3000000;
   localparam int DrainWait  = 400;
   localparam int RowMax     = 4096;
   localparam int WidthMax   = 4096;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_data;

   disparity_to_point_cloud_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the camera setup and the pixel position counters.
   logic [15:0] cam_focal, cam_baseline, cam_cx, cam_cy;
   logic [12:0] cam_line_w;
   logic        cam_wide;
   logic [7:0]  cam_white;
   int unsigned pix_col, pix_row;

   rsp_type     point_q[$];
   int          err_count;
   int          cycle_count;

   // When the item on the bus carries a hand-typed point, it is pinned here.
   logic        pin_valid;
   rsp_type     pin_point;

   // Stimulus table row: either a register write or one pixel item.
   typedef struct {
      bit          is_reg;
      logic [2:0]  idx;
      logic [15:0] val;
      req_type     pix;
      bit          pinned;
      rsp_type     point;
   } step_type;

   step_type    script[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Projection of one axis: trunc toward zero of zq*delta/f, saturated to 32 bits.
   function automatic logic [31:0] project_axis(longint unsigned zq, longint delta,
                                                longint unsigned f);
      longint unsigned mag;
      longint unsigned q;
      mag = (delta < 0) ? longint'(-delta) : longint'(delta);
      q = (zq * mag) / f;
      if (delta < 0) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   // Computes the point for one pixel and advances the column and row counters.
   function automatic rsp_type reproject_pixel(req_type pix);
      rsp_type         pt;
      longint unsigned f;
      longint unsigned dv;
      longint unsigned coef;
      longint unsigned zq;
      int unsigned     width;
      if (pix.frame_start) begin
         pix_col = 1;
         pix_row = 1;
      end
      f    = (cam_focal == 0) ? 1 : cam_focal;
      dv   = cam_wide ? pix.disparity : pix.disparity[7:0];
      coef = cam_wide ? 16 : 4;
      pt   = '0;
      if (dv != 0) begin
         zq = (longint'(cam_baseline) * f * coef) / dv;
         pt.point_x = project_axis(zq, longint'(pix_col) * 16 - longint'(cam_cx), f);
         pt.point_y = project_axis(zq, longint'(pix_row) * 16 - longint'(cam_cy), f);
         pt.point_z = (zq > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : zq[30:0];
      end
      pt.out_red   = pix.red;
      pt.out_green = pix.green;
      pt.out_blue  = pix.blue;
      if (pix.red > cam_white && pix.green > cam_white && pix.blue > cam_white) pt = '0;
      width = (cam_line_w == 0) ? 1 : cam_line_w;
      if (width > WidthMax) width = WidthMax;
      if (pix_col >= width) begin
         pix_col = 1;
         if (pix_row < RowMax) pix_row++;
      end else begin
         pix_col = (pix_col + 1) & 13'h1FFF;
      end
      return pt;
   endfunction

   function automatic void compare_point(rsp_type exp_pt, rsp_type act_pt);
      if (act_pt.point_x !== exp_pt.point_x) begin
         $error("point_x expected %0d got %0d", exp_pt.point_x, act_pt.point_x);
         err_count++;
      end
      if (act_pt.point_y !== exp_pt.point_y) begin
         $error("point_y expected %0d got %0d", exp_pt.point_y, act_pt.point_y);
         err_count++;
      end
      if (act_pt.point_z !== exp_pt.point_z) begin
         $error("point_z expected %0d got %0d", exp_pt.point_z, act_pt.point_z);
         err_count++;
      end
      if (act_pt.out_red !== exp_pt.out_red) begin
         $error("out_red expected %0d got %0d", exp_pt.out_red, act_pt.out_red);
         err_count++;
      end
      if (act_pt.out_green !== exp_pt.out_green) begin
         $error("out_green expected %0d got %0d", exp_pt.out_green, act_pt.out_green);
         err_count++;
      end
      if (act_pt.out_blue !== exp_pt.out_blue) begin
         $error("out_blue expected %0d got %0d", exp_pt.out_blue, act_pt.out_blue);
         err_count++;
      end
   endfunction

   // Monitor: everything is sampled at the rising edge, after the inputs settled
   // at the falling edge. Results are checked before new expectations are queued,
   // so a point leaving and a pixel entering on the same edge stay in order.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > RunLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (point_q.size() == 0) begin
               $error("point item arrived with no pixel outstanding");
               err_count++;
            end else begin
               compare_point(point_q.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            rsp_type pt;
            pt = reproject_pixel(req_data);
            point_q.push_back(pin_valid ? pin_point : pt);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FOCAL:    cam_focal    = csr_data;
               REG_BASELINE: cam_baseline = csr_data;
               REG_CENTER_X: cam_cx       = csr_data;
               REG_CENTER_Y: cam_cy       = csr_data;
               REG_LINE_W:   cam_line_w   = csr_data[12:0];
               REG_WIDE:     cam_wide     = csr_data[0];
               REG_WHITE:    cam_white    = csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   // Receiver: stalls in randomly drawn patterns, and once holds
   // off for a long stretch so the core backs up and stops taking pixels.
   initial begin
      int  rcv_cycles;
      int  mode;
      bit  long_hold_done;
      rsp_ready = 1'b0;
      rcv_cycles = 0;
      long_hold_done = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && rcv_cycles >= 3000) begin
            rsp_ready = 1'b0;
            repeat (2500) @(negedge clock);
            long_hold_done = 1;
         end
         if (rcv_cycles % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = $urandom_range(0, 1);
            2: rsp_ready = ($urandom_range(0, 3) == 0);
            default: rsp_ready = ($urandom_range(0, 15) != 0);
         endcase
         rcv_cycles++;
         @(negedge clock);
      end
   end

   int burst_left;

   // Offers one pixel; the sender drops valid only for a gap between bursts.
   task automatic send_pixel(req_type pix, bit pinned, rsp_type pt);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         pin_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_data  = pix;
      pin_valid = pinned;
      pin_point = pt;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Waits until every point has come back, then lets the core settle.
   task automatic wait_drained();
      req_valid = 1'b0;
      pin_valid = 1'b0;
      while (point_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type pixel(logic [15:0] disp, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic fs);
      req_type p;
      p.disparity = disp;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.frame_start = fs;
      return p;
   endfunction

   function automatic void add_reg(logic [2:0] idx, logic [15:0] val);
      step_type s;
      s = '{default: '0};
      s.is_reg = 1;
      s.idx = idx;
      s.val = val;
      script.push_back(s);
   endfunction

   function automatic void add_pix(req_type p, bit pinned, rsp_type pt);
      step_type s;
      s = '{default: '0};
      s.pix = p;
      s.pinned = pinned;
      s.point = pt;
      script.push_back(s);
   endfunction

   function automatic rsp_type color_only(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rsp_type pt;
      pt = '0;
      pt.out_red = r;
      pt.out_green = g;
      pt.out_blue = b;
      return pt;
   endfunction

   // Draws a disparity that covers the small, narrow-only and full ranges.
   function automatic logic [15:0] random_disparity();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 3));
         2: return {8'($urandom_range(1, 255)), 8'h00};
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes a full camera setup; the first ones are the corner cases.
   task automatic load_setup(int phase);
      logic [15:0] v[7];
      case (phase)
         0: v = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd0};
         1: v = '{16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd4096, 16'd0, 16'd255};
         2: v = '{16'd1, 16'd1, 16'd65535, 16'd65535, 16'd8191, 16'd1, 16'd128};
         3: v = '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd254};
         default: begin
            v[0] = 16'($urandom_range(1, 65535));
            v[1] = 16'($urandom);
            v[2] = 16'($urandom_range(0, 200));
            v[3] = 16'($urandom_range(0, 200));
            v[4] = 16'($urandom_range(2, 12));
            v[5] = 16'($urandom_range(0, 1));
            v[6] = 16'($urandom_range(100, 255));
         end
      endcase
      for (int i = 0; i < 7; i++) write_reg(3'(i), v[i]);
   endtask

   initial begin
      req_type pix;
      rsp_type none;
      int      n_items;
      logic [7:0] r, g, b;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_FOCAL;
      csr_data = '0;
      pin_valid = 1'b0;
      pin_point = '0;
      err_count = 0;
      cycle_count = 0;
      burst_left = 0;
      none = '0;
      cam_focal = 16'd1;
      cam_baseline = 16'd0;
      cam_cx = 16'd0;
      cam_cy = 16'd0;
      cam_line_w = 13'd640;
      cam_wide = 1'b0;
      cam_white = 8'd255;
      pix_col = 1;
      pix_row = 1;

      // Directed table. With the reset setup the baseline is zero, so every
      // point is zero and the colors pass through untouched.
      add_pix(pixel(16'h0000, 8'h00, 8'h00, 8'h00, 1'b1), 1, color_only(0, 0, 0));
      add_pix(pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1, color_only(255, 255, 255));
      add_pix(pixel(16'h0001, 8'h12, 8'h34, 8'h56, 1'b0), 1,
              color_only(8'h12, 8'h34, 8'h56));
      // Narrow disparity with a nonzero baseline; the high byte must be ignored.
      add_reg(REG_FOCAL, 16'd160);
      add_reg(REG_BASELINE, 16'd120);
      add_reg(REG_CENTER_X, 16'd40);
      add_reg(REG_CENTER_Y, 16'd24);
      add_reg(REG_LINE_W, 16'd3);
      add_reg(REG_WHITE, 16'd200);
      add_pix(pixel(16'hAB00, 8'd7, 8'd8, 8'd9, 1'b1), 1, color_only(7, 8, 9));
      add_pix(pixel(16'hAB01, 8'd7, 8'd8, 8'd9, 1'b0), 0, none);
      add_pix(pixel(16'h00FF, 8'd1, 8'd2, 8'd3, 1'b0), 0, none);
      add_pix(pixel(16'h0010, 8'd201, 8'd201, 8'd201, 1'b0), 1, none);
      add_pix(pixel(16'h0010, 8'd200, 8'd255, 8'd255, 1'b0), 0, none);
      add_pix(pixel(16'h0002, 8'd0, 8'd0, 8'd0, 1'b0), 0, none);
      add_pix(pixel(16'h0003, 8'd0, 8'd0, 8'd0, 1'b1), 0, none);
      // Wide disparity, then saturation of depth and of both axes.
      add_reg(REG_WIDE, 16'd1);
      add_pix(pixel(16'hAB00, 8'd5, 8'd5, 8'd5, 1'b0), 0, none);
      add_pix(pixel(16'h0000, 8'd5, 8'd6, 8'd7, 1'b0), 1, color_only(5, 6, 7));
      add_reg(REG_FOCAL, 16'd65535);
      add_reg(REG_BASELINE, 16'd65535);
      add_reg(REG_CENTER_X, 16'd65535);
      add_reg(REG_CENTER_Y, 16'd0);
      add_pix(pixel(16'h0001, 8'd1, 8'd1, 8'd1, 1'b1), 0, none);
      add_pix(pixel(16'hFFFF, 8'd1, 8'd1, 8'd1, 1'b0), 0, none);
      // A zero focal length counts as one.
      add_reg(REG_FOCAL, 16'd0);
      add_pix(pixel(16'h0001, 8'd2, 8'd2, 8'd2, 1'b0), 0, none);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].is_reg) begin
            wait_drained();
            write_reg(script[i].idx, script[i].val);
         end else begin
            send_pixel(script[i].pix, script[i].pinned, script[i].point);
         end
      end

      // Random phases, each under its own camera setup.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         load_setup(phase);
         n_items = (phase < 4) ? 100 : 200;
         for (int i = 0; i < n_items; i++) begin
            if (phase == 6 && i == n_items / 2) wait_drained();
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
               r = 8'($urandom_range(cam_white, 255));
               g = 8'($urandom_range(cam_white, 255));
               b = 8'($urandom_range(cam_white, 255));
            end
            pix = pixel(random_disparity(), r, g, b,
                        (i == 0) || ($urandom_range(0, 49) == 0));
            send_pixel(pix, 0, none);
         end
      end

      // A zero line width acts as one pixel per row, so every pixel starts a
      // new row. Mostly zero disparity keeps this phase short.
      wait_drained();
      write_reg(REG_LINE_W, 16'd0);
      write_reg(REG_BASELINE, 16'd300);
      write_reg(REG_CENTER_Y, 16'd0);
      for (int i = 0; i < 400; i++) begin
         pix = pixel((i % 64 == 0 || i > 380) ? 16'($urandom_range(1, 65535)) : 16'd0,
                     8'($urandom), 8'($urandom), 8'($urandom), i == 0);
         send_pixel(pix, 0, none);
      end

      req_valid = 1'b0;
      pin_valid = 1'b0;
      while (point_q.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
